// ===== rtl/core/ccp_pkg.sv =====
// Shared types, character codes and helper functions of the connect command parser.
`default_nettype none

package ccp_pkg;

  // Parse phases, one-hot.
  typedef enum logic [8:0] {
    PH_LEAD     = 9'b0_0000_0001,
    PH_KEY      = 9'b0_0000_0010,
    PH_AFTERKEY = 9'b0_0000_0100,
    PH_GAP      = 9'b0_0000_1000,
    PH_OCTET    = 9'b0_0001_0000,
    PH_DOT      = 9'b0_0010_0000,
    PH_SEP      = 9'b0_0100_0000,
    PH_PORT     = 9'b0_1000_0000,
    PH_TAIL     = 9'b1_0000_0000
  } phase_e;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Octet overflow guard: an octet above 25, or 25 followed by a digit above 5, overflows.
  localparam logic [7:0]  OCTET_GUARD = 8'd25;
  localparam logic [3:0]  DIGIT_GUARD = 4'd5;
  // Port accumulator saturation value and largest legal port.
  localparam logic [16:0] PORT_SAT    = 17'd65536;
  localparam logic [16:0] PORT_MAX    = 17'd65535;
  // Keyword length and the octet index of the last octet.
  localparam logic [2:0]  KW_LEN      = 3'd7;
  localparam logic [1:0]  LAST_OCTET  = 2'd3;
  // Largest value the byte count field can show.
  localparam int unsigned COUNT_FIELD_MAX = 127;

  // One input beat.
  typedef struct packed {
    logic [7:0] ch;
    logic       last_byte;
    logic [2:0] conn_slot;
  } beat_t;

  // One result item.
  typedef struct packed {
    logic        accepted;
    logic [31:0] ip_address;
    logic [15:0] port_number;
    logic [2:0]  slot_out;
    logic [6:0]  byte_count;
  } result_t;

  // Character of the keyword "connect" at a given position.
  function automatic logic [7:0] kw_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h63;  // c
      3'd1:    c = 8'h6F;  // o
      3'd2:    c = 8'h6E;  // n
      3'd3:    c = 8'h6E;  // n
      3'd4:    c = 8'h65;  // e
      3'd5:    c = 8'h63;  // c
      3'd6:    c = 8'h74;  // t
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/connect_command_parser.sv =====
// Top level of the connect command parser: input register, parser and result register.
//
// Usage. The input channel carries one byte of a control write per beat
// (ch_i, last_byte_i, conn_slot_i); last_byte_i marks the final byte. The
// output channel carries one result beat per write: accepted_o, ip_address_o,
// port_number_o, slot_out_o and byte_count_o. Address and port read zero on
// a reject. Both channels use valid and stall; a beat moves at a rising edge
// with valid high and stall low.
// Throughput is one byte per cycle, back to back, across write boundaries,
// while no last byte waits on a stalled result register. A taken byte sits
// in the input register and is parsed from there; the result of a last byte
// is loaded into the result register, from which it can be taken. The one-byte
// parse step, a small state update, sets the cycle. When the receiver stalls,
// the result waits in the result register; bytes that are not last keep
// flowing, and a last byte waits in the input register until the result
// register frees, input stall high meanwhile. Reset clears the parse state,
// the slot and both valid flags; the block takes bytes as soon as reset ends.
`default_nettype none

module connect_command_parser
  import ccp_pkg::*;
#(
  parameter int unsigned MAX_COMMAND_BYTES = 64,
  parameter int unsigned MAX_CONNS         = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [7:0]  ch_i,
  input  wire logic        last_byte_i,
  input  wire logic [2:0]  conn_slot_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic        accepted_o,
  output      logic [31:0] ip_address_o,
  output      logic [15:0] port_number_o,
  output      logic [2:0]  slot_out_o,
  output      logic [6:0]  byte_count_o
);

  logic    s1_valid_q, s1_valid_d;
  beat_t   s1_q;
  logic    s1_fire;
  logic    in_take;
  logic    out_free;
  logic    out_valid_q, out_valid_d;
  result_t out_q;
  result_t res;

  // Handshake: a beat leaves the input register unless it is a last byte
  // meeting a full, stalled result register.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!s1_q.last_byte || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_take    = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_take || (s1_valid_q && !s1_fire);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= '{ch: ch_i, last_byte: last_byte_i, conn_slot: conn_slot_i};
    end
  end

  ccp_parser #(
    .MAX_COMMAND_BYTES (MAX_COMMAND_BYTES),
    .MAX_CONNS         (MAX_CONNS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s1_fire),
    .beat_i   (s1_q),
    .result_o (res)
  );

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && s1_q.last_byte) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_q.last_byte) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = out_q.accepted;
  assign ip_address_o  = out_q.ip_address;
  assign port_number_o = out_q.port_number;
  assign slot_out_o    = out_q.slot_out;
  assign byte_count_o  = out_q.byte_count;

  // A last byte is only parsed when its result has somewhere to go.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_q.last_byte) |-> out_free)
    else $error("result register overwritten while stalled");

  // An accepted command always carries a non-zero port.
  a_accept_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && accepted_o) |-> (port_number_o != 16'd0))
    else $error("accepted command with port zero");

  // A rejected command shows neither address nor port.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !accepted_o) |-> (ip_address_o == 32'd0 && port_number_o == 16'd0))
    else $error("rejected command with address or port");

  // Every write counts at least its last byte.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_count_o != 7'd0))
    else $error("result with zero byte count");

endmodule

`default_nettype wire

// ===== rtl/core/ccp_parser.sv =====
// Parse state registers and the per-byte next-state and verdict logic.
`default_nettype none

module ccp_parser
  import ccp_pkg::*;
#(
  parameter int unsigned MAX_COMMAND_BYTES = 64,
  parameter int unsigned MAX_CONNS         = 8
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    fire_i,
  input  wire beat_t   beat_i,
  output result_t      result_o
);

  localparam int unsigned CntW = $clog2(MAX_COMMAND_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_COMMAND_BYTES);
  localparam logic [8:0] ConnLimit = 9'(MAX_CONNS);

  phase_e          phase_q, phase_d;
  logic [2:0]      kw_q, kw_d;
  logic [7:0]      oct_q, oct_d;
  logic [1:0]      idx_q, idx_d;
  logic [31:0]     addr_q, addr_d;
  logic [16:0]     port_q, port_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            fail_q, fail_d;
  logic            ended_q, ended_d;
  logic [2:0]      slot_q, slot_d;

  logic [7:0]  ch;
  logic [3:0]  dig;
  logic        bad;
  logic [20:0] port_prod;
  logic        ok;

  assign ch        = beat_i.ch;
  assign dig       = ch[3:0];
  assign port_prod = {4'b0, port_q} * 21'd10 + 21'(dig);

  // Next state after one byte, before the end-of-write clear.
  always_comb begin
    slot_d  = (cnt_q == '0) ? beat_i.conn_slot : slot_q;
    cnt_d   = (cnt_q < CntMax) ? cnt_q + 1'b1 : cnt_q;
    phase_d = phase_q;
    kw_d    = kw_q;
    oct_d   = oct_q;
    idx_d   = idx_q;
    addr_d  = addr_q;
    port_d  = port_q;
    ended_d = ended_q;
    bad     = 1'b0;
    if (!ended_q && !fail_q) begin
      if (ch == CH_NUL) begin
        ended_d = 1'b1;
      end else begin
        unique case (phase_q)
          PH_LEAD: begin
            if (ch == kw_char(3'd0)) begin
              kw_d    = 3'd1;
              phase_d = PH_KEY;
            end else if (ch != CH_SPACE) begin
              bad = 1'b1;
            end
          end
          PH_KEY: begin
            if (ch == kw_char(kw_q)) begin
              kw_d = kw_q + 3'd1;
              if (kw_d == KW_LEN) begin
                phase_d = PH_AFTERKEY;
              end
            end else begin
              bad = 1'b1;
            end
          end
          PH_AFTERKEY: begin
            if (ch == CH_SPACE) begin
              phase_d = PH_GAP;
            end else begin
              bad = 1'b1;
            end
          end
          PH_GAP: begin
            if (is_digit(ch)) begin
              oct_d   = {4'b0, dig};
              idx_d   = 2'd0;
              phase_d = PH_OCTET;
            end else if (ch != CH_SPACE) begin
              bad = 1'b1;
            end
          end
          PH_DOT: begin
            if (is_digit(ch)) begin
              oct_d   = {4'b0, dig};
              phase_d = PH_OCTET;
            end else begin
              bad = 1'b1;
            end
          end
          PH_OCTET: begin
            if (is_digit(ch)) begin
              if ((oct_q > OCTET_GUARD) || ((oct_q == OCTET_GUARD) && (dig > DIGIT_GUARD))) begin
                bad = 1'b1;
              end else begin
                oct_d = 8'({4'b0, oct_q} * 12'd10 + 12'(dig));
              end
            end else if (idx_q != LAST_OCTET) begin
              if (ch == CH_DOT) begin
                addr_d  = {addr_q[23:0], oct_q};
                idx_d   = idx_q + 2'd1;
                phase_d = PH_DOT;
              end else begin
                bad = 1'b1;
              end
            end else if (is_ws(ch)) begin
              addr_d  = {addr_q[23:0], oct_q};
              phase_d = PH_SEP;
            end else begin
              bad = 1'b1;
            end
          end
          PH_SEP: begin
            if (is_digit(ch)) begin
              port_d  = {13'b0, dig};
              phase_d = PH_PORT;
            end else if (!is_ws(ch)) begin
              bad = 1'b1;
            end
          end
          PH_PORT: begin
            if (is_digit(ch)) begin
              port_d = (port_prod > 21'(PORT_SAT)) ? PORT_SAT : 17'(port_prod);
            end else if (is_ws(ch)) begin
              phase_d = PH_TAIL;
            end else begin
              bad = 1'b1;
            end
          end
          PH_TAIL: begin
            if (!is_ws(ch)) begin
              bad = 1'b1;
            end
          end
          default: bad = 1'b1;
        endcase
      end
    end
    fail_d = fail_q | bad;
  end

  // Verdict on the state as it stands after this byte.
  always_comb begin
    ok = !fail_d
      && ((phase_d == PH_PORT) || (phase_d == PH_TAIL))
      && (port_d != '0) && (port_d <= PORT_MAX)
      && (cnt_d < CntMax)
      && (9'(slot_d) < ConnLimit);
    result_o.accepted    = ok;
    result_o.ip_address  = ok ? addr_d : 32'd0;
    result_o.port_number = ok ? port_d[15:0] : 16'd0;
    result_o.slot_out    = slot_d;
    result_o.byte_count  = (32'(cnt_d) > COUNT_FIELD_MAX) ? 7'(COUNT_FIELD_MAX) : 7'(cnt_d);
  end

  // State registers; the last byte of a write clears the parse for the next one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      kw_q    <= '0;
      oct_q   <= '0;
      idx_q   <= '0;
      addr_q  <= '0;
      port_q  <= '0;
      cnt_q   <= '0;
      fail_q  <= 1'b0;
      ended_q <= 1'b0;
      slot_q  <= '0;
    end else if (fire_i) begin
      slot_q <= slot_d;
      if (beat_i.last_byte) begin
        phase_q <= PH_LEAD;
        kw_q    <= '0;
        oct_q   <= '0;
        idx_q   <= '0;
        addr_q  <= '0;
        port_q  <= '0;
        cnt_q   <= '0;
        fail_q  <= 1'b0;
        ended_q <= 1'b0;
      end else begin
        phase_q <= phase_d;
        kw_q    <= kw_d;
        oct_q   <= oct_d;
        idx_q   <= idx_d;
        addr_q  <= addr_d;
        port_q  <= port_d;
        cnt_q   <= cnt_d;
        fail_q  <= fail_d;
        ended_q <= ended_d;
      end
    end
  end

  // A finished write leaves a clean parse behind.
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && beat_i.last_byte) |=> (cnt_q == '0 && !fail_q && !ended_q && phase_q == PH_LEAD))
    else $error("parse state not cleared after the last beat");

  // The port accumulator never passes its saturation value.
  a_port_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    port_q <= PORT_SAT)
    else $error("port accumulator above saturation");

  // The byte count never passes the command limit.
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("byte count above the command limit");

endmodule

`default_nettype wire

// ===== tb/sv/tb_connect_command_parser.sv =====
// Self-checking testbench of the connect command parser: directed table, random writes, predictor.
module tb_connect_command_parser;
  import ccp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_COMMAND_BYTES = 64;
  localparam int unsigned MAX_CONNS         = 8;
  localparam int          RANDOM_BEATS      = 60;
  localparam int          HOLD_CYCLES       = 300;
  localparam int          IDLE_LIMIT        = 2000;
  localparam int          DRAIN_CYCLES      = 8;
  localparam int          PRINT_CAP         = 100;
  // In the directed table this character stands for a NUL byte.
  localparam logic [7:0]  NUL_MARK          = 8'h7E;

  typedef logic [7:0] byte_q_t[$];

  // One queued input beat, with an optional hand-written reply for a last byte.
  typedef struct packed {
    beat_t   b;
    logic    typed;
    result_t reply;
  } stim_t;

  // One row of the directed table.
  typedef struct {
    string       text;
    int          pad_to;
    logic [2:0]  slot;
    bit          typed;
    logic        acc;
    logic [31:0] ip;
    logic [15:0] port;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  ch;
  logic        last_byte;
  logic [2:0]  conn_slot;
  logic        out_valid;
  logic        out_stall;
  logic        accepted;
  logic [31:0] ip_address;
  logic [15:0] port_number;
  logic [2:0]  slot_out;
  logic [6:0]  byte_count;

  connect_command_parser #(
    .MAX_COMMAND_BYTES(MAX_COMMAND_BYTES),
    .MAX_CONNS        (MAX_CONNS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .ch_i         (ch),
    .last_byte_i  (last_byte),
    .conn_slot_i  (conn_slot),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .accepted_o   (accepted),
    .ip_address_o (ip_address),
    .port_number_o(port_number),
    .slot_out_o   (slot_out),
    .byte_count_o (byte_count)
  );

  // Directed writes: extremes, every parse phase and many of the ways a write can fail.
  row_t directed_rows[22] = '{
    '{"connect 255.255.255.255 65535", 0, 3'd7, 1'b1, 1'b1, 32'hFFFF_FFFF, 16'd65535},
    '{"connect 0.0.0.0 1", 0, 3'd0, 1'b1, 1'b1, 32'h0000_0000, 16'd1},
    '{"  connect  010.001.000.099\r\n00080\r\n", 0, 3'd3, 1'b1, 1'b1, 32'h0A01_0063, 16'd80},
    '{"connect 1.2.3.4 0", 0, 3'd1, 1'b1, 1'b0, 32'h0, 16'h0},
    '{"connect 1.2.3.4 65536", 0, 3'd2, 1'b1, 1'b0, 32'h0, 16'h0},
    '{"connect 1.2.3.256 80", 0, 3'd4, 1'b1, 1'b0, 32'h0, 16'h0},
    '{"connect 10.0.0.1 8080~junk", 0, 3'd5, 1'b1, 1'b1, 32'h0A00_0001, 16'd8080},
    '{"connect 10.0.0.1~ 80", 0, 3'd6, 1'b1, 1'b0, 32'h0, 16'h0},
    '{"connect~ 1.2.3.4 80", 0, 3'd7, 1'b1, 1'b0, 32'h0, 16'h0},
    '{"connectx 1.2.3.4 5", 0, 3'd0, 1'b1, 1'b0, 32'h0, 16'h0},
    '{"connect 1.2.3.4", 0, 3'd1, 1'b1, 1'b0, 32'h0, 16'h0},
    '{"connect 1.2.3.4 80", 63, 3'd2, 1'b1, 1'b1, 32'h0102_0304, 16'd80},
    '{"connect 1.2.3.4 80", 64, 3'd3, 1'b1, 1'b0, 32'h0, 16'h0},
    '{"connect 1.2.3.4 80", 70, 3'd4, 1'b1, 1'b0, 32'h0, 16'h0},
    '{"connect 1.2.3.4 80x", 0, 3'd5, 1'b1, 1'b0, 32'h0, 16'h0},
    '{"connect 1.2.3 4 80", 0, 3'd6, 1'b1, 1'b0, 32'h0, 16'h0},
    '{"x", 0, 3'd7, 1'b1, 1'b0, 32'h0, 16'h0},
    '{"~", 0, 3'd0, 1'b1, 1'b0, 32'h0, 16'h0},
    '{"connect 99.199.249.255 443 ", 0, 3'd1, 1'b0, 1'b0, 32'h0, 16'h0},
    '{"connect 1..2.3.4 5", 0, 3'd2, 1'b1, 1'b0, 32'h0, 16'h0},
    '{"conn ect 1.2.3.4 5", 0, 3'd3, 1'b1, 1'b0, 32'h0, 16'h0},
    '{"connect 1.2.3.4\n07\n", 0, 3'd4, 1'b0, 1'b0, 32'h0, 16'h0}
  };

  // Predictor state of the parser.
  phase_e      parse_phase;
  logic [2:0]  kw_pos;
  logic [7:0]  octet_val;
  logic [1:0]  octet_num;
  logic [31:0] addr_val;
  logic [16:0] port_val;
  logic [6:0]  byte_total;
  bit          parse_failed;
  bit          text_ended;
  logic [2:0]  latched_slot;
  string       keyword = "connect";

  stim_t   beat_plan[$];
  stim_t   cur_stim;
  result_t pending_replies[$];
  int      fail_count;
  int      idle_cycles;
  int      hold_left;
  bit      hold_request;
  int      pressure_at;
  int      plan_goal;
  int      burst_left;
  int      gap;
  byte_q_t row_text;
  result_t row_reply;

  always #2 clk_i = ~clk_i;

  function automatic bit digit_char(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit blank_char(input logic [7:0] c);
    return c == CH_SPACE || c == CH_CR || c == CH_LF;
  endfunction

  task automatic clear_parse_state();
    parse_phase  = PH_LEAD;
    kw_pos       = '0;
    octet_val    = '0;
    octet_num    = '0;
    addr_val     = '0;
    port_val     = '0;
    byte_total   = '0;
    parse_failed = 1'b0;
    text_ended   = 1'b0;
  endtask

  // Advances the parser by one byte; a last byte yields the reply of the write.
  task automatic parse_command_byte(input beat_t b, output bit emit, output result_t r);
    logic [7:0]  c;
    logic [7:0]  d;
    bit          bad;
    bit          ok;
    int unsigned wide;
    c    = b.ch;
    d    = c - CH_ZERO;
    emit = 1'b0;
    r    = '0;
    if (byte_total == 0) latched_slot = b.conn_slot;
    if (byte_total < MAX_COMMAND_BYTES) byte_total = byte_total + 1'b1;
    if (!text_ended && !parse_failed) begin
      if (c == CH_NUL) begin
        text_ended = 1'b1;
      end else begin
        bad = 1'b0;
        case (parse_phase)
          PH_LEAD: begin
            if (c == keyword[0]) begin
              kw_pos      = 3'd1;
              parse_phase = PH_KEY;
            end else if (c != CH_SPACE) begin
              bad = 1'b1;
            end
          end
          PH_KEY: begin
            if (c == keyword[kw_pos]) begin
              kw_pos = kw_pos + 1'b1;
              if (kw_pos == KW_LEN) parse_phase = PH_AFTERKEY;
            end else begin
              bad = 1'b1;
            end
          end
          PH_AFTERKEY: begin
            if (c == CH_SPACE) parse_phase = PH_GAP;
            else bad = 1'b1;
          end
          PH_GAP: begin
            if (digit_char(c)) begin
              octet_val   = d;
              octet_num   = '0;
              parse_phase = PH_OCTET;
            end else if (c != CH_SPACE) begin
              bad = 1'b1;
            end
          end
          PH_DOT: begin
            if (digit_char(c)) begin
              octet_val   = d;
              parse_phase = PH_OCTET;
            end else begin
              bad = 1'b1;
            end
          end
          PH_OCTET: begin
            if (digit_char(c)) begin
              // A digit that would push the octet above 255 fails the write.
              if (octet_val > OCTET_GUARD || (octet_val == OCTET_GUARD && d > DIGIT_GUARD))
                bad = 1'b1;
              else
                octet_val = octet_val * 8'd10 + d;
            end else if (octet_num < LAST_OCTET) begin
              if (c == CH_DOT) begin
                addr_val    = {addr_val[23:0], octet_val};
                octet_num   = octet_num + 1'b1;
                parse_phase = PH_DOT;
              end else begin
                bad = 1'b1;
              end
            end else if (blank_char(c)) begin
              addr_val    = {addr_val[23:0], octet_val};
              parse_phase = PH_SEP;
            end else begin
              bad = 1'b1;
            end
          end
          PH_SEP: begin
            if (digit_char(c)) begin
              port_val    = {9'd0, d};
              parse_phase = PH_PORT;
            end else if (!blank_char(c)) begin
              bad = 1'b1;
            end
          end
          PH_PORT: begin
            if (digit_char(c)) begin
              // The port saturates just past its legal range.
              wide     = int'(port_val) * 10 + int'(d);
              port_val = (wide > PORT_SAT) ? PORT_SAT : wide[16:0];
            end else if (blank_char(c)) begin
              parse_phase = PH_TAIL;
            end else begin
              bad = 1'b1;
            end
          end
          PH_TAIL: begin
            if (!blank_char(c)) bad = 1'b1;
          end
          default: bad = 1'b1;
        endcase
        if (bad) parse_failed = 1'b1;
      end
    end
    if (b.last_byte) begin
      ok = !parse_failed && (parse_phase == PH_PORT || parse_phase == PH_TAIL)
           && port_val >= 1 && port_val <= PORT_MAX
           && byte_total < MAX_COMMAND_BYTES && latched_slot < MAX_CONNS;
      r.accepted    = ok;
      r.ip_address  = ok ? addr_val : '0;
      r.port_number = ok ? port_val[15:0] : '0;
      r.slot_out    = latched_slot;
      r.byte_count  = byte_total;
      emit          = 1'b1;
      clear_parse_state();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < PRINT_CAP)
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic byte_q_t row_bytes(input string text, input int pad_to);
    byte_q_t q;
    for (int i = 0; i < text.len(); i++)
      q.push_back((text[i] == NUL_MARK) ? CH_NUL : text[i]);
    while (q.size() < pad_to) q.push_back(CH_SPACE);
    return q;
  endfunction

  function automatic string blank_run(input int n, input bit mixed);
    string s;
    int    r;
    s = "";
    repeat (n) begin
      r = mixed ? $urandom_range(0, 2) : 0;
      s = {s, (r == 0) ? " " : (r == 1) ? "\r" : "\n"};
    end
    return s;
  endfunction

  // One random write: mostly well-formed commands with random numbers, some broken or noise.
  function automatic byte_q_t random_command();
    byte_q_t q;
    string   s;
    int      kind;
    int      r;
    int      n;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      n = $urandom_range(1, 24);
      repeat (n) q.push_back(8'($urandom_range(0, 255)));
      return q;
    end
    s = {blank_run($urandom_range(0, 2), 1'b0), "connect", blank_run($urandom_range(1, 2), 1'b0)};
    for (int o = 0; o < 4; o++) begin
      r = $urandom_range(0, 15);
      case (r)
        0:       s = {s, $sformatf("%0d", $urandom_range(256, 999))};
        1:       s = {s, $sformatf("%03d", $urandom_range(0, 255))};
        2:       s = {s, "255"};
        3:       s = {s, "0"};
        default: s = {s, $sformatf("%0d", $urandom_range(0, 255))};
      endcase
      if (o < 3) s = {s, "."};
    end
    s = {s, blank_run($urandom_range(1, 2), 1'b1)};
    r = $urandom_range(0, 11);
    case (r)
      0:       s = {s, "0"};
      1:       s = {s, "65536"};
      2:       s = {s, "65535"};
      3:       s = {s, $sformatf("%0d", $urandom_range(65537, 999999))};
      4:       s = {s, $sformatf("000%0d", $urandom_range(1, 999))};
      5, 6:    s = {s, $sformatf("%0d", $urandom_range(1, 9))};
      default: s = {s, $sformatf("%0d", $urandom_range(1, 65535))};
    endcase
    s = {s, blank_run($urandom_range(0, 2), 1'b1)};
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    case (kind)
      1: q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
      2: q = q[0 : $urandom_range(0, q.size() - 1)];
      3: begin
        q.push_back(CH_NUL);
        repeat ($urandom_range(0, 4)) q.push_back(8'($urandom_range(0, 255)));
      end
      4: q[$urandom_range(0, q.size() - 1)] = CH_NUL;
      default: ;
    endcase
    // Now and then a write grows to around the length limit.
    if ($urandom_range(0, 24) == 0) begin
      n = $urandom_range(60, 70);
      while (q.size() < n) q.push_back(CH_SPACE);
    end
    return q;
  endfunction

  // Splits one write into beats; the slot only matters on the first byte.
  task automatic queue_write(input byte_q_t bytes, input logic [2:0] slot, input bit typed,
                             input result_t reply);
    stim_t s;
    for (int i = 0; i < bytes.size(); i++) begin
      s.b.ch        = bytes[i];
      s.b.last_byte = (i == bytes.size() - 1);
      s.b.conn_slot = (i == 0) ? slot : 3'($urandom_range(0, 7));
      s.typed       = typed && s.b.last_byte;
      s.reply       = reply;
      beat_plan.push_back(s);
    end
  endtask

  // Input beats feed the predictor; result beats are checked against the oldest reply.
  always @(posedge clk_i) begin
    bit      emit;
    result_t predicted;
    result_t got;
    if (rst_ni && in_valid && !in_stall) begin
      parse_command_byte(cur_stim.b, emit, predicted);
      if (emit) pending_replies.push_back(cur_stim.typed ? cur_stim.reply : predicted);
    end
    if (rst_ni && out_valid && !out_stall) begin
      got = '{accepted, ip_address, port_number, slot_out, byte_count};
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected result beat", {31'd0, got.accepted}, 32'd0);
      end else begin
        predicted = pending_replies.pop_front();
        if (got.accepted !== predicted.accepted)
          report_mismatch("accepted", 32'(got.accepted), 32'(predicted.accepted));
        if (got.ip_address !== predicted.ip_address)
          report_mismatch("ip_address", got.ip_address, predicted.ip_address);
        if (got.port_number !== predicted.port_number)
          report_mismatch("port_number", 32'(got.port_number), 32'(predicted.port_number));
        if (got.slot_out !== predicted.slot_out)
          report_mismatch("slot_out", 32'(got.slot_out), 32'(predicted.slot_out));
        if (got.byte_count !== predicted.byte_count)
          report_mismatch("byte_count", 32'(got.byte_count), 32'(predicted.byte_count));
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: stall pattern in modes of random length, plus one long hold-off on request.
  initial begin
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 64);
        end
        mode_left--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ~out_stall;
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Sender: builds the beat plan, then offers it in bursts with random gaps.
  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    ch           = '0;
    last_byte    = 1'b0;
    conn_slot    = '0;
    out_stall    = 1'b0;
    cur_stim     = '0;
    fail_count   = 0;
    idle_cycles  = 0;
    hold_left    = 0;
    hold_request = 1'b0;
    latched_slot = '0;
    clear_parse_state();

    foreach (directed_rows[i]) begin
      row_text              = row_bytes(directed_rows[i].text, directed_rows[i].pad_to);
      row_reply.accepted    = directed_rows[i].acc;
      row_reply.ip_address  = directed_rows[i].ip;
      row_reply.port_number = directed_rows[i].port;
      row_reply.slot_out    = directed_rows[i].slot;
      row_reply.byte_count  = (row_text.size() >= MAX_COMMAND_BYTES) ?
                              7'(MAX_COMMAND_BYTES) : 7'(row_text.size());
      queue_write(row_text, directed_rows[i].slot, directed_rows[i].typed, row_reply);
    end
    // The long hold-off starts halfway through the table, with many short writes still to come.
    pressure_at = beat_plan.size() / 2;
    plan_goal   = beat_plan.size() + RANDOM_BEATS;
    while (beat_plan.size() < plan_goal)
      queue_write(random_command(), 3'($urandom_range(0, 7)), 1'b0, '0);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    burst_left = $urandom_range(1, 20);
    foreach (beat_plan[k]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        // Keep offering while the receiver holds off, so the block fills up.
        if (hold_request || hold_left != 0) gap = 0;
        if (gap > 0) begin
          @(negedge clk_i);
          in_valid <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end
      end
      burst_left--;
      @(negedge clk_i);
      in_valid  <= 1'b1;
      ch        <= beat_plan[k].b.ch;
      last_byte <= beat_plan[k].b.last_byte;
      conn_slot <= beat_plan[k].b.conn_slot;
      cur_stim   = beat_plan[k];
      @(posedge clk_i);
      while (in_stall) @(posedge clk_i);
      if (k == pressure_at) hold_request = 1'b1;
    end
    @(negedge clk_i);
    in_valid <= 1'b0;

    // Drain the outstanding replies, then watch for strays.
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
